>>> rtl/rlc_pkg.sv
package rlc_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // working width of the updated count: one clamped count plus two amounts
   localparam int SUM_WIDTH   = VALUE_WIDTH + 2;
   // distance outside the range, always below 2**(VALUE_WIDTH+1)
   localparam int DIV_WIDTH   = VALUE_WIDTH + 1;
   localparam int ITER_WIDTH  = $clog2(DIV_WIDTH + 1);

   localparam logic [VALUE_WIDTH-1:0] RANGE_HIGH_RESET = VALUE_WIDTH'(64'd10 << FRAC_BITS);

   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RANGE_LOW  = 2'd0,
      CSR_RANGE_HIGH = 2'd1,
      CSR_LIMIT_MODE = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_WRAP     = 1'b0,
      MODE_SATURATE = 1'b1
   } limit_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_ADD,
      ST_SUB,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH,
      ST_RESPOND
   } state_type;

endpackage

>>> rtl/rlc_req_if.sv
interface rlc_req_if;
   import rlc_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] up_amount;
   logic                          up_flag;
   logic signed [VALUE_WIDTH-1:0] down_amount;
   logic                          down_flag;
   logic signed [VALUE_WIDTH-1:0] load_value;
   logic                          load_flag;

   modport source (
      output valid, up_amount, up_flag, down_amount, down_flag, load_value, load_flag,
      input  ready
   );

   modport sink (
      input  valid, up_amount, up_flag, down_amount, down_flag, load_value, load_flag,
      output ready
   );

endinterface

>>> rtl/rlc_rsp_if.sv
interface rlc_rsp_if;
   import rlc_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] count_out;

   modport source (
      output valid, count_out,
      input  ready
   );

   modport sink (
      input  valid, count_out,
      output ready
   );

endinterface

>>> rtl/rlc_csr_if.sv
interface rlc_csr_if;
   import rlc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [VALUE_WIDTH-1:0]     data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );

endinterface

>>> rtl/range_limited_up_down_counter.sv
// channel   dir  modport  word
// req_bus   in   sink     up/down amounts and flags, load value and flag
// rsp_bus   out  source   count_out, one word per request word
// csr_bus   in   sink     index 0 range_low, 1 range_high, 2 limit_mode
//
// one request word passes accept, 4 update steps, 33 remainder steps, finish and response
// when the count wraps, else accept, update steps and response; plus any response stall.
// the pace is set by the restoring remainder unit, one quotient bit per cycle.
// req_bus is not ready until the response word has been taken.
// reset is synchronous: count 0, range [0, 10.0], wrap mode.
// csr_bus is always ready.
module range_limited_up_down_counter (
   input logic      clock,
   input logic      reset,
   rlc_req_if.sink  req_bus,
   rlc_rsp_if.source rsp_bus,
   rlc_csr_if.sink  csr_bus
);
   import rlc_pkg::*;

   state_type                     state_ff, state_in;

   logic signed [VALUE_WIDTH-1:0] range_low_ff, range_high_ff;
   limit_mode_type                limit_mode_ff;
   logic signed [VALUE_WIDTH-1:0] tally_ff, tally_in;

   logic signed [VALUE_WIDTH-1:0] up_amount_ff, up_amount_in;
   logic                          up_flag_ff, up_flag_in;
   logic signed [VALUE_WIDTH-1:0] down_amount_ff, down_amount_in;
   logic                          down_flag_ff, down_flag_in;
   logic signed [VALUE_WIDTH-1:0] load_value_ff, load_value_in;
   logic                          load_flag_ff, load_flag_in;

   logic signed [SUM_WIDTH-1:0]   acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0]        span_ff, span_in;
   logic                          above_ff, above_in;
   logic [DIV_WIDTH-1:0]          dividend_ff, dividend_in;
   logic [VALUE_WIDTH-1:0]        rem_ff, rem_in;
   logic [ITER_WIDTH-1:0]         iter_ff, iter_in;
   logic [VALUE_WIDTH-1:0]        result_ff, result_in;

   logic signed [SUM_WIDTH-1:0]   low_ext, high_ext, diff_high, diff_low;
   logic [DIV_WIDTH:0]            trial;
   logic [DIV_WIDTH-1:0]          shifted;

   assign low_ext   = SUM_WIDTH'(range_low_ff);
   assign high_ext  = SUM_WIDTH'(range_high_ff);
   assign diff_high = acc_ff - high_ext;
   assign diff_low  = low_ext - acc_ff;

   // restoring remainder step: bring in the next dividend bit, subtract span if it fits
   assign shifted = {rem_ff, dividend_ff[DIV_WIDTH-1]};
   assign trial   = {1'b0, shifted} - {2'b00, span_ff};

   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.count_out = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= RANGE_HIGH_RESET;
         limit_mode_ff <= MODE_WRAP;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_RANGE_LOW:  range_low_ff  <= csr_bus.data;
            CSR_RANGE_HIGH: range_high_ff <= csr_bus.data;
            CSR_LIMIT_MODE: limit_mode_ff <= limit_mode_type'(csr_bus.data[0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tally_ff <= '0;
      end else begin
         state_ff <= state_in;
         tally_ff <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      up_amount_ff   <= up_amount_in;
      up_flag_ff     <= up_flag_in;
      down_amount_ff <= down_amount_in;
      down_flag_ff   <= down_flag_in;
      load_value_ff  <= load_value_in;
      load_flag_ff   <= load_flag_in;
      acc_ff         <= acc_in;
      span_ff        <= span_in;
      above_ff       <= above_in;
      dividend_ff    <= dividend_in;
      rem_ff         <= rem_in;
      iter_ff        <= iter_in;
      result_ff      <= result_in;
   end

   always_comb begin
      state_in       = state_ff;
      tally_in       = tally_ff;
      up_amount_in   = up_amount_ff;
      up_flag_in     = up_flag_ff;
      down_amount_in = down_amount_ff;
      down_flag_in   = down_flag_ff;
      load_value_in  = load_value_ff;
      load_flag_in   = load_flag_ff;
      acc_in         = acc_ff;
      span_in        = span_ff;
      above_in       = above_ff;
      dividend_in    = dividend_ff;
      rem_in         = rem_ff;
      iter_in        = iter_ff;
      result_in      = result_ff;
      req_bus.ready  = 1'b0;
      rsp_bus.valid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               up_amount_in   = req_bus.up_amount;
               up_flag_in     = req_bus.up_flag;
               down_amount_in = req_bus.down_amount;
               down_flag_in   = req_bus.down_flag;
               load_value_in  = req_bus.load_value;
               load_flag_in   = req_bus.load_flag;
               state_in       = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            // high bound first, low bound second
            acc_in = SUM_WIDTH'(tally_ff);
            if (tally_ff > range_high_ff) begin
               acc_in = high_ext;
            end
            if (tally_ff < range_low_ff && range_high_ff >= range_low_ff) begin
               acc_in = low_ext;
            end else if (tally_ff <= range_high_ff && tally_ff < range_low_ff) begin
               acc_in = low_ext;
            end else if (range_high_ff < range_low_ff) begin
               acc_in = low_ext;
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (up_flag_ff) begin
               acc_in = acc_ff + SUM_WIDTH'(up_amount_ff);
            end
            span_in  = VALUE_WIDTH'(range_high_ff - range_low_ff);
            state_in = ST_SUB;
         end
         ST_SUB: begin
            if (load_flag_ff) begin
               acc_in = SUM_WIDTH'(load_value_ff);
            end else if (down_flag_ff) begin
               acc_in = acc_ff - SUM_WIDTH'(down_amount_ff);
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            rem_in   = '0;
            iter_in  = '0;
            state_in = ST_RESPOND;
            if (range_low_ff >= range_high_ff) begin
               result_in = range_low_ff;
            end else if (limit_mode_ff == MODE_SATURATE) begin
               if (diff_high > 0) begin
                  result_in = range_high_ff;
               end else if (diff_low > 0) begin
                  result_in = range_low_ff;
               end else begin
                  result_in = acc_ff[VALUE_WIDTH-1:0];
               end
            end else if (diff_high > 0) begin
               above_in    = 1'b1;
               dividend_in = diff_high[DIV_WIDTH-1:0];
               state_in    = ST_DIVIDE;
            end else if (diff_low > 0) begin
               above_in    = 1'b0;
               dividend_in = diff_low[DIV_WIDTH-1:0];
               state_in    = ST_DIVIDE;
            end else begin
               result_in = acc_ff[VALUE_WIDTH-1:0];
            end
         end
         ST_DIVIDE: begin
            if (!trial[DIV_WIDTH]) begin
               rem_in = trial[VALUE_WIDTH-1:0];
            end else begin
               rem_in = shifted[VALUE_WIDTH-1:0];
            end
            dividend_in = {dividend_ff[DIV_WIDTH-2:0], 1'b0};
            iter_in     = iter_ff + 1'b1;
            if (iter_ff == ITER_WIDTH'(DIV_WIDTH - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (above_ff) begin
               result_in = range_low_ff + rem_ff;
            end else begin
               result_in = range_high_ff - rem_ff;
            end
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready) begin
               tally_in = result_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_one_side_open: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request and response open together");

   a_no_early_word: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !rsp_bus.valid)
      else $error("response word right after accept");

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE && span_ff != '0 |-> rem_ff < span_ff)
      else $error("partial remainder not below span");

   a_tally_from_word: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready |=> tally_ff == $past(rsp_bus.count_out))
      else $error("stored count differs from delivered word");
`endif

endmodule
